// ===== hdl/tcp_syn_thinning_filter_macros.svh =====
// Assertion macros used by the SYN thinning filter top level.
`ifndef TCP_SYN_THINNING_FILTER_MACROS_SVH
`define TCP_SYN_THINNING_FILTER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TSF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsf assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsf assertion failed");

`endif

// ===== hdl/tsf_pkg.sv =====
// Package with types and constants of the SYN thinning filter.
`timescale 1ns / 1ps
package tsf_pkg;

  localparam int NUM_VERDICTS_DEFAULT = 5;

  localparam int SYN_W    = 32;
  localparam int STAT_W   = 64;
  localparam int PERIOD_W = 16;
  localparam int PORT_W   = 16;
  localparam int LEN_W    = 16;
  localparam int ETYPE_W  = 16;
  localparam int PROTO_W  = 8;
  localparam int VERDICT_W = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam int DIV_STEPS = SYN_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [VERDICT_W-1:0] VERDICT_ABORTED = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DROP    = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_PASS    = 2'd2;

  localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [PROTO_W-1:0] PROTO_TCP      = 8'd6;

  localparam logic [CFG_INDEX_W-1:0] REG_DROP_PERIOD  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WATCHED_PORT = 1'd1;

  localparam logic [PERIOD_W-1:0] DROP_PERIOD_RESET  = 16'd4;
  localparam logic [PORT_W-1:0]   WATCHED_PORT_RESET = 16'd4444;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DONE
  } tsf_state_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } tsf_rem_status_t;

endpackage

// ===== hdl/tsf_rem_serial.sv =====
// Bit-serial restoring remainder unit that tests a count against the drop period.
`timescale 1ns / 1ps
module tsf_rem_serial (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tsf_pkg::SYN_W-1:0]      dividend,
  input  logic [tsf_pkg::PERIOD_W-1:0]   divisor,
  output tsf_pkg::tsf_rem_status_t       status
);
  import tsf_pkg::*;

  logic [STEP_W-1:0]   steps;
  logic                done;
  logic [SYN_W-1:0]    dvd;
  logic [PERIOD_W:0]   rem;
  logic                dvd_zero;
  logic                div_zero;
  logic [PERIOD_W:0]   rem_shift;
  logic [PERIOD_W:0]   divisor_ext;
  logic [PERIOD_W:0]   rem_next;

  always_comb begin
    rem_shift   = {rem[PERIOD_W-1:0], dvd[SYN_W-1]};
    divisor_ext = {1'b0, divisor};
    if (rem_shift >= divisor_ext) begin
      rem_next = rem_shift - divisor_ext;
    end else begin
      rem_next = rem_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= (steps == STEP_W'(1));
      if (start) begin
        steps <= STEP_W'(DIV_STEPS);
      end else if (steps != '0) begin
        steps <= steps - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      rem      <= '0;
      dvd_zero <= (dividend == '0);
      div_zero <= (divisor == '0);
    end else if (steps != '0) begin
      dvd <= {dvd[SYN_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  // A zero divisor leaves the count itself as the remainder.
  assign status.done     = done;
  assign status.rem_zero = div_zero ? dvd_zero : (rem == '0);

endmodule

// ===== hdl/tsf_stats.sv =====
// Per-verdict packet and byte counters with read-modify-write update.
`timescale 1ns / 1ps
module tsf_stats #(
  parameter int NUM_VERDICTS = tsf_pkg::NUM_VERDICTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           update,
  input  logic [tsf_pkg::VERDICT_W-1:0]  verdict,
  input  logic [tsf_pkg::LEN_W-1:0]      length,
  output logic [tsf_pkg::STAT_W-1:0]     packets_new,
  output logic [tsf_pkg::STAT_W-1:0]     bytes_new
);
  import tsf_pkg::*;

  localparam int IDX_W = $clog2(NUM_VERDICTS);

  logic [STAT_W-1:0] packets [NUM_VERDICTS];
  logic [STAT_W-1:0] bytes   [NUM_VERDICTS];
  logic [IDX_W:0]    verdict_ext;
  logic [IDX_W-1:0]  idx;
  logic              in_range;

  always_comb begin
    verdict_ext = (IDX_W + 1)'(verdict);
    idx         = verdict_ext[IDX_W-1:0];
    in_range    = (verdict_ext < (IDX_W + 1)'(NUM_VERDICTS));
    if (in_range) begin
      packets_new = packets[idx] + STAT_W'(1);
      bytes_new   = bytes[idx] + STAT_W'(length);
    end else begin
      packets_new = '0;
      bytes_new   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VERDICTS; i++) begin
        packets[i] <= '0;
        bytes[i]   <= '0;
      end
    end else if (update && in_range) begin
      packets[idx] <= packets_new;
      bytes[idx]   <= bytes_new;
    end
  end

endmodule

// ===== hdl/tcp_syn_thinning_filter.sv =====
// Top level of the TCP SYN thinning filter: classification, sequencing and output beat.
// A frame that is not a watched SYN goes from IDLE through DONE to the output beat; a watched SYN
// also passes through DIVIDE, where the 32-step bit-serial remainder unit sets its verdict.
// The block takes one frame at a time: the input stalls until that frame's output beat is loaded.
// Reset clears all counters, the SYN count and the handshake state, and loads the
// register defaults (drop period 4, watched port 4444).
`timescale 1ns / 1ps
`include "tcp_syn_thinning_filter_macros.svh"
module tcp_syn_thinning_filter #(
  parameter int NUM_VERDICTS = tsf_pkg::NUM_VERDICTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [tsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              headers_present,
  input  logic [tsf_pkg::ETYPE_W-1:0]       ethertype,
  input  logic [tsf_pkg::PROTO_W-1:0]       ip_protocol,
  input  logic                              syn_flag,
  input  logic [tsf_pkg::PORT_W-1:0]        dest_port,
  input  logic [tsf_pkg::LEN_W-1:0]         frame_length,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tsf_pkg::VERDICT_W-1:0]     verdict,
  output logic [tsf_pkg::SYN_W-1:0]         syn_total,
  output logic [tsf_pkg::STAT_W-1:0]        verdict_packets,
  output logic [tsf_pkg::STAT_W-1:0]        verdict_bytes
);
  import tsf_pkg::*;

  tsf_state_t          state;
  tsf_state_t          state_next;
  logic [PERIOD_W-1:0] drop_period;
  logic [PORT_W-1:0]   watched_port;
  logic [SYN_W-1:0]    syn_counter;
  logic [SYN_W-1:0]    syn_counter_next;
  logic [VERDICT_W-1:0] verdict_hold;
  logic [LEN_W-1:0]    len_hold;
  logic                accept;
  logic                match;
  logic                div_start;
  logic                out_load;
  tsf_rem_status_t     rem_st;
  logic [STAT_W-1:0]   packets_new;
  logic [STAT_W-1:0]   bytes_new;

  always_comb begin
    match = headers_present && (ethertype == ETHERTYPE_IPV4) &&
            (ip_protocol == PROTO_TCP) && syn_flag && (dest_port == watched_port);
    syn_counter_next = syn_counter + SYN_W'(1);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = match ? ST_DIVIDE : ST_DONE;
        end
      end
      ST_DIVIDE: begin
        if (rem_st.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_DIVIDE: in_stall = 1'b1;
      ST_DONE:   out_load = !out_valid || !out_stall;
      default:   in_stall = 1'b1;
    endcase
    accept    = in_valid && !in_stall;
    div_start = accept && match;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      drop_period  <= DROP_PERIOD_RESET;
      watched_port <= WATCHED_PORT_RESET;
      syn_counter  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DROP_PERIOD:  drop_period  <= cfg_data[PERIOD_W-1:0];
          REG_WATCHED_PORT: watched_port <= cfg_data[PORT_W-1:0];
          default: ;
        endcase
      end
      if (div_start) begin
        syn_counter <= syn_counter_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      verdict_hold <= headers_present ? VERDICT_PASS : VERDICT_ABORTED;
      len_hold     <= frame_length;
    end else if (state == ST_DIVIDE && rem_st.done) begin
      verdict_hold <= rem_st.rem_zero ? VERDICT_PASS : VERDICT_DROP;
    end
    if (out_load) begin
      verdict         <= verdict_hold;
      syn_total       <= syn_counter;
      verdict_packets <= packets_new;
      verdict_bytes   <= bytes_new;
    end
  end

  tsf_rem_serial u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (syn_counter_next),
    .divisor  (drop_period),
    .status   (rem_st)
  );

  tsf_stats #(
    .NUM_VERDICTS (NUM_VERDICTS)
  ) u_stats (
    .clk         (clk),
    .rst         (rst),
    .update      (out_load),
    .verdict     (verdict_hold),
    .length      (len_hold),
    .packets_new (packets_new),
    .bytes_new   (bytes_new)
  );

  `TSF_ASSERT_NEXT(a_syn_enters_divide, clk, rst, div_start, state == ST_DIVIDE)
  `TSF_ASSERT_NEXT(a_syn_count_steps, clk, rst, div_start,
                   syn_counter == $past(syn_counter) + SYN_W'(1))
  `TSF_ASSERT_SAME(a_done_only_in_divide, clk, rst, rem_st.done, state == ST_DIVIDE)
  `TSF_ASSERT_NEXT(a_done_waits_for_room, clk, rst,
                   state == ST_DONE && out_valid && out_stall, state == ST_DONE)

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the TCP SYN thinning filter.
`timescale 1ns / 1ps
module testbench;
  import tsf_pkg::*;

  localparam int VERDICT_SLOTS = NUM_VERDICTS_DEFAULT;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic present;
    logic [ETYPE_W-1:0] etype;
    logic [PROTO_W-1:0] proto;
    logic syn;
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0] len;
  } frame_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [SYN_W-1:0] syn;
    logic [STAT_W-1:0] packets;
    logic [STAT_W-1:0] bytes;
  } syn_result_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic headers_present;
  logic [ETYPE_W-1:0] ethertype;
  logic [PROTO_W-1:0] ip_protocol;
  logic syn_flag;
  logic [PORT_W-1:0] dest_port;
  logic [LEN_W-1:0] frame_length;
  logic out_valid;
  logic out_stall;
  logic [VERDICT_W-1:0] verdict;
  logic [SYN_W-1:0] syn_total;
  logic [STAT_W-1:0] verdict_packets;
  logic [STAT_W-1:0] verdict_bytes;

  // Predictor state: mirrors the block's registers and counters.
  logic [PERIOD_W-1:0] drop_period;
  logic [PORT_W-1:0] watch_port;
  logic [SYN_W-1:0] syn_count;
  logic [STAT_W-1:0] pkt_count [VERDICT_SLOTS];
  logic [STAT_W-1:0] byte_count [VERDICT_SLOTS];

  syn_result_t expected_verdicts [$];
  int frames_sent;
  int settings_used;
  int mismatches;
  int aborted_seen;
  int dropped_seen;
  int passed_seen;
  int hold_left;
  bit steady;

  tcp_syn_thinning_filter u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .headers_present(headers_present),
    .ethertype(ethertype),
    .ip_protocol(ip_protocol),
    .syn_flag(syn_flag),
    .dest_port(dest_port),
    .frame_length(frame_length),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict(verdict),
    .syn_total(syn_total),
    .verdict_packets(verdict_packets),
    .verdict_bytes(verdict_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d verdicts outstanding.", expected_verdicts.size());
    $display("tcp_syn_thinning_filter verification failed");
    $finish;
  end

  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < 17);
  endfunction

  function automatic syn_result_t judge_frame(frame_t f);
    syn_result_t r;
    logic [SYN_W-1:0] leftover;
    r.verdict = VERDICT_PASS;
    if (!f.present) begin
      r.verdict = VERDICT_ABORTED;
    end else if (f.etype == ETHERTYPE_IPV4 && f.proto == PROTO_TCP && f.syn &&
                 f.port == watch_port) begin
      syn_count = syn_count + 1'b1;
      // A zero period leaves the count itself as the remainder.
      leftover = (drop_period == '0) ? syn_count : syn_count % drop_period;
      if (leftover != '0) r.verdict = VERDICT_DROP;
    end
    pkt_count[r.verdict] = pkt_count[r.verdict] + 1'b1;
    byte_count[r.verdict] = byte_count[r.verdict] + f.len;
    r.syn = syn_count;
    r.packets = pkt_count[r.verdict];
    r.bytes = byte_count[r.verdict];
    return r;
  endfunction

  function automatic frame_t make_frame(logic present, logic [ETYPE_W-1:0] etype,
                                        logic [PROTO_W-1:0] proto, logic syn,
                                        logic [PORT_W-1:0] port, logic [LEN_W-1:0] len);
    frame_t f;
    f.present = present;
    f.etype = etype;
    f.proto = proto;
    f.syn = syn;
    f.port = port;
    f.len = len;
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int roll;
    roll = $urandom_range(99);
    f.present = 1'b1;
    f.etype = ETHERTYPE_IPV4;
    f.proto = PROTO_TCP;
    f.syn = ($urandom_range(99) < 70);
    f.port = ($urandom_range(99) < 65) ? watch_port : PORT_W'($urandom);
    f.len = ($urandom_range(3) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(1514, 60));
    if (roll < 8) begin
      f.present = 1'b0;
      f.etype = ETYPE_W'($urandom);
      f.proto = PROTO_W'($urandom);
    end else if (roll < 16) begin
      f.etype = ETYPE_W'($urandom);
    end else if (roll < 24) begin
      f.proto = PROTO_W'($urandom);
    end
    return f;
  endfunction

  // Starts and ends on a falling edge; records the expected verdict on acceptance.
  task automatic send_frame(frame_t f);
    while (idle_roll()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    headers_present = f.present;
    ethertype = f.etype;
    ip_protocol = f.proto;
    syn_flag = f.syn;
    dest_port = f.port;
    frame_length = f.len;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_verdicts.push_back(judge_frame(f));
    frames_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic settle();
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    if (idx == REG_DROP_PERIOD) drop_period = value;
    else watch_port = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic run_setting(logic [PERIOD_W-1:0] period, logic [PORT_W-1:0] port,
                             int syn_beats, int random_beats);
    settle();
    write_reg(REG_DROP_PERIOD, period);
    write_reg(REG_WATCHED_PORT, port);
    settings_used++;
    repeat (syn_beats) begin
      send_frame(make_frame(1'b1, ETHERTYPE_IPV4, PROTO_TCP, 1'b1, port,
                            LEN_W'($urandom)));
    end
    repeat (random_beats) send_frame(random_frame());
  endtask

  task automatic test_directed_defaults();
    send_frame(make_frame(1'b0, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF));
    send_frame(make_frame(1'b0, ETHERTYPE_IPV4, PROTO_TCP, 1'b1, watch_port, 16'd64));
    send_frame(make_frame(1'b1, 16'h86DD, PROTO_TCP, 1'b1, watch_port, 16'd0));
    send_frame(make_frame(1'b1, 16'h0000, PROTO_TCP, 1'b1, watch_port, 16'd60));
    send_frame(make_frame(1'b1, 16'hFFFF, PROTO_TCP, 1'b1, watch_port, 16'd61));
    send_frame(make_frame(1'b1, ETHERTYPE_IPV4, 8'd17, 1'b1, watch_port, 16'd90));
    send_frame(make_frame(1'b1, ETHERTYPE_IPV4, 8'hFF, 1'b1, watch_port, 16'd91));
    send_frame(make_frame(1'b1, ETHERTYPE_IPV4, 8'h00, 1'b1, watch_port, 16'd92));
    send_frame(make_frame(1'b1, ETHERTYPE_IPV4, PROTO_TCP, 1'b0, watch_port, 16'd1500));
    send_frame(make_frame(1'b1, ETHERTYPE_IPV4, PROTO_TCP, 1'b1, watch_port + 1'b1, 16'd70));
    send_frame(make_frame(1'b1, ETHERTYPE_IPV4, PROTO_TCP, 1'b1, 16'h0000, 16'd71));
    send_frame(make_frame(1'b1, ETHERTYPE_IPV4, PROTO_TCP, 1'b1, 16'hFFFF, 16'd72));
    send_frame(make_frame(1'b1, ETHERTYPE_IPV4, PROTO_TCP, 1'b1, watch_port, 16'hFFFF));
    send_frame(make_frame(1'b1, ETHERTYPE_IPV4, PROTO_TCP, 1'b1, watch_port, 16'd1));
    send_frame(make_frame(1'b1, ETHERTYPE_IPV4, PROTO_TCP, 1'b1, watch_port, 16'd1514));
    send_frame(make_frame(1'b1, ETHERTYPE_IPV4, PROTO_TCP, 1'b1, watch_port, 16'd0));
    send_frame(make_frame(1'b1, ETHERTYPE_IPV4, PROTO_TCP, 1'b1, watch_port, 16'hFFFF));
  endtask

  task automatic test_register_settings();
    run_setting(16'd1, 16'd0, 4, 3);
    run_setting(16'd0, 16'hFFFF, 4, 3);
    run_setting(16'hFFFF, 16'd4444, 3, 2);
    run_setting(16'd3, 16'd80, 7, 3);
    run_setting(16'd2, 16'd443, 4, 2);
  endtask

  task automatic test_backpressure();
    settle();
    steady = 1'b1;
    hold_left = HOLD_CYCLES;
    repeat (8) send_frame(random_frame());
    settle();
    repeat (5) send_frame(random_frame());
    settle();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [PERIOD_W-1:0] periods [6];
    logic [PORT_W-1:0] ports [6];
    periods = '{16'd7, 16'd1, 16'hFFFF, 16'd0, 16'd3, 16'd4};
    ports = '{16'd22, 16'd8080, 16'd4444, 16'd1, 16'hFFFF, 16'd4444};
    for (int i = 0; i < 6; i++) begin
      steady = (i == 2);
      run_setting(periods[i], ports[i], 0, 80);
    end
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = idle_roll();
    end
  end

  always @(posedge clk) begin : verdict_checker
    syn_result_t got;
    syn_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{verdict, syn_total, verdict_packets, verdict_bytes};
      case (got.verdict)
        VERDICT_ABORTED: aborted_seen++;
        VERDICT_DROP: dropped_seen++;
        default: passed_seen++;
      endcase
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected beat: verdict %0d syn %0d packets %0d bytes %0d",
                   got.verdict, got.syn, got.packets, got.bytes);
      end else begin
        want = expected_verdicts.pop_front();
        if (got.verdict !== want.verdict || got.syn !== want.syn ||
            got.packets !== want.packets || got.bytes !== want.bytes) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: expected verdict %0d syn %0d packets %0d bytes %0d",
                     $realtime, want.verdict, want.syn, want.packets, want.bytes);
            $display("  got verdict %0d syn %0d packets %0d bytes %0d",
                     got.verdict, got.syn, got.packets, got.bytes);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_DROP_PERIOD;
    cfg_data = '0;
    in_valid = 1'b0;
    headers_present = 1'b0;
    ethertype = '0;
    ip_protocol = '0;
    syn_flag = 1'b0;
    dest_port = '0;
    frame_length = '0;
    out_stall = 1'b0;
    hold_left = 0;
    steady = 1'b0;
    drop_period = DROP_PERIOD_RESET;
    watch_port = WATCHED_PORT_RESET;
    syn_count = '0;
    for (int i = 0; i < VERDICT_SLOTS; i++) begin
      pkt_count[i] = '0;
      byte_count[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_directed_defaults();
    test_register_settings();
    test_backpressure();
    test_random_traffic();

    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("Covered %0d frames under %0d register settings plus the reset defaults.",
             frames_sent, settings_used);
    $display("Verdicts seen: %0d aborted, %0d dropped, %0d passed; %0d mismatches.",
             aborted_seen, dropped_seen, passed_seen, mismatches);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("tcp_syn_thinning_filter verification clean");
    end else begin
      $display("tcp_syn_thinning_filter verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tsf_pkg.sv
hdl/tsf_rem_serial.sv
hdl/tsf_stats.sv
hdl/tcp_syn_thinning_filter.sv
verif/testbench.sv
